// ===== hdl/owtr_pkg.sv =====
// shared types and constants of the one-wire temperature reader
package owtr_pkg;

   // widest phase duration, covers every legal time counter width
   localparam int unsigned DUR_BITS = 24;

   localparam int unsigned RST_TIME_BITS  = 12;
   localparam int unsigned CONV_TIME_BITS = 18;
   localparam int unsigned SLOT_TIME_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 18;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned TEMP_BITS      = 16;

   // fixed bus timing in microseconds
   localparam logic [DUR_BITS-1:0] SHORT_US       = DUR_BITS'(1);
   localparam logic [DUR_BITS-1:0] READ_LOW_US    = DUR_BITS'(2);
   localparam logic [DUR_BITS-1:0] READ_SAMPLE_US = DUR_BITS'(8);

   // command bytes: skip rom, convert, skip rom, read scratchpad
   localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0] CMD_CONVERT    = 8'h44;
   localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;
   localparam logic [7:0] CMD_BYTES [4]  = '{CMD_SKIP_ROM, CMD_CONVERT,
                                             CMD_SKIP_ROM, CMD_READ_SCRPD};
   localparam logic [1:0] CMD_IDX_CONVERT = 2'd1;
   localparam logic [1:0] CMD_IDX_READ    = 2'd3;

   // reset values of the control registers
   localparam logic [RST_TIME_BITS-1:0]  RESET_LOW_DEFAULT  = 12'd480;
   localparam logic [RST_TIME_BITS-1:0]  RESET_REL_DEFAULT  = 12'd480;
   localparam logic [CONV_TIME_BITS-1:0] CONVERT_DEFAULT    = 18'd200000;
   localparam logic [SLOT_TIME_BITS-1:0] SLOT_DEFAULT       = 8'd60;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RESET_LOW   = 2'd0,
      CSR_RESET_REL   = 2'd1,
      CSR_CONVERT     = 2'd2,
      CSR_SLOT        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_RST_LOW = 3'd1,
      PH_RST_REL = 3'd2,
      PH_WR_LOW  = 3'd3,
      PH_WR_HIGH = 3'd4,
      PH_CONV    = 3'd5,
      PH_RD_LOW  = 3'd6,
      PH_RD_HIGH = 3'd7
   } phase_type;

   typedef struct packed {
      logic [RST_TIME_BITS-1:0]  reset_low_time;
      logic [RST_TIME_BITS-1:0]  reset_release_time;
      logic [CONV_TIME_BITS-1:0] convert_wait_time;
      logic [SLOT_TIME_BITS-1:0] slot_time;
   } cfg_type;

   typedef struct packed {
      logic                        drive_low;
      logic                        busy_res;
      logic                        reading_valid;
      logic signed [TEMP_BITS-1:0] temperature;
   } result_type;

endpackage

// ===== hdl/owtr_sequencer.sv =====
// bus sequencer: phase state machine, phase timer and read shifter
module owtr_sequencer #(
   parameter int unsigned COUNT_BITS = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                start_request,
   input  logic                line_level,
   input  owtr_pkg::cfg_type   cfg,
   output owtr_pkg::result_type result
);
   import owtr_pkg::*;

   localparam logic [DUR_BITS-1:0] CNT_MAX = DUR_BITS'((64'd1 << COUNT_BITS) - 64'd1);

   phase_type                   phase_ff,  phase_in;
   logic [1:0]                  cmd_ff,    cmd_in;
   logic [3:0]                  bit_ff,    bit_in;
   logic [COUNT_BITS-1:0]       time_ff,   time_in;
   logic [TEMP_BITS-1:0]        shift_ff,  shift_in;
   logic [TEMP_BITS-1:0]        last_ff,   last_in;

   logic [COUNT_BITS-1:0] time_inc;
   logic [DUR_BITS-1:0]   dur;
   logic [DUR_BITS-1:0]   dur_cl;
   logic                  done;
   logic                  cur_bit;
   logic                  valid;
   logic [7:0]            cmd_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         bit_ff   <= '0;
         time_ff  <= '0;
         shift_ff <= '0;
         last_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         bit_ff   <= bit_in;
         time_ff  <= time_in;
         shift_ff <= shift_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      cmd_byte = CMD_BYTES[cmd_ff];
      cur_bit  = cmd_byte[bit_ff[2:0]];
      time_inc = time_ff + COUNT_BITS'(1);

      unique case (phase_ff)
         PH_IDLE:    dur = '0;
         PH_RST_LOW: dur = DUR_BITS'(cfg.reset_low_time);
         PH_RST_REL: dur = DUR_BITS'(cfg.reset_release_time);
         PH_WR_LOW:  dur = cur_bit ? SHORT_US : DUR_BITS'(cfg.slot_time);
         PH_WR_HIGH: dur = cur_bit ? DUR_BITS'(cfg.slot_time) : SHORT_US;
         PH_CONV:    dur = DUR_BITS'(cfg.convert_wait_time);
         PH_RD_LOW:  dur = READ_LOW_US;
         PH_RD_HIGH: dur = READ_SAMPLE_US + DUR_BITS'(cfg.slot_time);
      endcase
      dur_cl = (dur > CNT_MAX) ? CNT_MAX : dur;
      done   = DUR_BITS'(time_inc) >= dur_cl;

      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      bit_in   = bit_ff;
      time_in  = (phase_ff == PH_IDLE) ? time_ff : (done ? '0 : time_inc);
      shift_in = shift_ff;
      last_in  = last_ff;
      valid    = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               phase_in = PH_RST_LOW;
               cmd_in   = '0;
               bit_in   = '0;
               time_in  = '0;
            end
         end
         PH_RST_LOW: begin
            if (done) phase_in = PH_RST_REL;
         end
         PH_RST_REL: begin
            if (done) begin
               phase_in = PH_WR_LOW;
               bit_in   = '0;
            end
         end
         PH_WR_LOW: begin
            if (done) phase_in = PH_WR_HIGH;
         end
         PH_WR_HIGH: begin
            if (done) begin
               if (bit_ff >= 4'd7) begin
                  bit_in = '0;
                  cmd_in = cmd_ff + 2'd1;
                  if (cmd_ff == CMD_IDX_CONVERT) begin
                     phase_in = PH_CONV;
                  end else if (cmd_ff == CMD_IDX_READ) begin
                     phase_in = PH_RD_LOW;
                     shift_in = '0;
                  end else begin
                     phase_in = PH_WR_LOW;
                  end
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_WR_LOW;
               end
            end
         end
         PH_CONV: begin
            if (done) phase_in = PH_RST_LOW;
         end
         PH_RD_LOW: begin
            if (done) phase_in = PH_RD_HIGH;
         end
         PH_RD_HIGH: begin
            // sample on the eighth released microsecond, lsb arrives first
            if (time_inc == COUNT_BITS'(READ_SAMPLE_US))
               shift_in = {line_level, shift_ff[TEMP_BITS-1:1]};
            if (done) begin
               if (bit_ff == 4'd15) begin
                  last_in  = shift_in;
                  valid    = 1'b1;
                  bit_in   = '0;
                  cmd_in   = '0;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_RD_LOW;
               end
            end
         end
      endcase

      result.drive_low     = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                             (phase_in == PH_RD_LOW);
      result.busy_res      = (phase_in != PH_IDLE);
      result.reading_valid = valid;
      result.temperature   = signed'(last_in);
   end

endmodule

// ===== hdl/onewire_temperature_reader.sv =====
// top level of the one-wire temperature reader: control registers and beat handshake
//
// one-wire bus master that reads a temperature sensor. each input beat is one
// microsecond tick: it carries the start request and the sampled data line level,
// and produces exactly one result beat with the line drive for the next
// microsecond, the busy flag, a one-tick reading flag and the last reading
// (signed, sixteenths of a degree). a reading runs: bus reset, skip rom and
// convert, conversion wait, second bus reset, skip rom and read scratchpad, then
// sixteen read slots, lsb first. the presence pulse is not checked. a start
// request while busy is ignored. the block takes one beat every clock cycle while
// results drain: the sequencer state is one register stage and the result sits in
// one output register, so a beat is accepted whenever the output register is empty
// or is being drained in the same cycle. the user must write control registers
// through the csr port only while no tick is in flight; the block does not enforce
// this. COUNT_BITS sets the phase timer width and longer durations clamp to it.
module onewire_temperature_reader #(
   parameter int unsigned COUNT_BITS = 18
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick beats in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_start_request,
   input  logic                                 req_line_level,
   // result beats out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_low,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_reading_valid,
   output logic signed [owtr_pkg::TEMP_BITS-1:0] rsp_temperature,
   // control register writes
   input  logic                                 csr_write_enable,
   input  logic [owtr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [owtr_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import owtr_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= RESET_LOW_DEFAULT;
         cfg_ff.reset_release_time <= RESET_REL_DEFAULT;
         cfg_ff.convert_wait_time  <= CONVERT_DEFAULT;
         cfg_ff.slot_time          <= SLOT_DEFAULT;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESET_LOW: cfg_ff.reset_low_time     <= csr_write_data[RST_TIME_BITS-1:0];
            CSR_RESET_REL: cfg_ff.reset_release_time <= csr_write_data[RST_TIME_BITS-1:0];
            CSR_CONVERT:   cfg_ff.convert_wait_time  <= csr_write_data[CONV_TIME_BITS-1:0];
            CSR_SLOT:      cfg_ff.slot_time          <= csr_write_data[SLOT_TIME_BITS-1:0];
         endcase
      end
   end

   // take a tick whenever the output register is free or leaving this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   owtr_sequencer #(
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .start_request (req_start_request),
      .line_level    (req_line_level),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // output register, valid flag reset, payload only loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_low     = rsp_ff.drive_low;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_reading_valid = rsp_ff.reading_valid;
   assign rsp_temperature   = rsp_ff.temperature;

endmodule

// ===== hdl/owtr_checker.sv =====
// port checker for the one-wire temperature reader and its bind
module owtr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_drive_low,
   input logic                                 rsp_busy_res,
   input logic                                 rsp_reading_valid,
   input logic signed [owtr_pkg::TEMP_BITS-1:0] rsp_temperature
);

   // a finished reading ends the sequence in the same beat
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reading_valid |-> !rsp_busy_res)
      else $error("reading flagged while still busy");

   // the line is only pulled low inside a sequence
   a_drive_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("line driven low while idle");

   // an empty output register always takes a tick
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("tick refused with empty output register");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature) &&
                                  $stable(rsp_reading_valid))
      else $error("stalled result beat changed");

endmodule

bind onewire_temperature_reader owtr_checker u_owtr_checker (.*);

// ===== tb/sv/onewire_temperature_reader_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the one-wire temperature reader, one beat per microsecond tick
module onewire_temperature_reader_test;
   import owtr_pkg::*;

   localparam int unsigned COUNT_BITS      = 18;
   localparam int unsigned TIMER_MAX       = (1 << COUNT_BITS) - 1;
   localparam int unsigned HALF_PERIOD     = 4;
   localparam int unsigned RESET_CYCLES    = 6;
   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int unsigned IDLE_PERCENT    = 30;

   // bus timing of the sensor protocol, in microseconds
   localparam int unsigned SHORT_PHASE_US = 1;
   localparam int unsigned READ_PULSE_US  = 2;
   localparam int unsigned SAMPLE_AT_US   = 8;

   // power-up register contents
   localparam int unsigned DEFAULT_RESET_LOW_US = 480;
   localparam int unsigned DEFAULT_RESET_REL_US = 480;
   localparam int unsigned DEFAULT_CONVERT_US   = 200000;
   localparam int unsigned DEFAULT_SLOT_US      = 60;

   // command bytes sent in order: skip rom, convert, skip rom, read scratchpad
   localparam logic [7:0] SKIP_ROM_CMD     = 8'hCC;
   localparam logic [7:0] CONVERT_CMD      = 8'h44;
   localparam logic [7:0] READ_SCRATCH_CMD = 8'hBE;
   localparam logic [7:0] COMMAND_SEQ [4]  = '{SKIP_ROM_CMD, CONVERT_CMD,
                                               SKIP_ROM_CMD, READ_SCRATCH_CMD};
   localparam logic [1:0] CONVERT_SLOT     = 2'd1;
   localparam logic [1:0] READ_SLOT        = 2'd3;

   // how start_request is driven while a reading is in progress
   typedef enum int unsigned {
      START_NEVER  = 0,
      START_ALWAYS = 1,
      START_RANDOM = 2
   } busy_start_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_start_request = 1'b0;
   logic                           req_line_level = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_drive_low;
   logic                           rsp_busy_res;
   logic                           rsp_reading_valid;
   logic signed [TEMP_BITS-1:0]    rsp_temperature;
   logic                           csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_write_data = '0;

   // bus master mirror: sequencer state and register copy
   phase_type                      bus_phase = PH_IDLE;
   logic [1:0]                     cmd_slot = '0;
   logic [3:0]                     bit_pos = '0;
   logic [COUNT_BITS-1:0]          phase_timer = '0;
   logic [TEMP_BITS-1:0]           scratch_bits = '0;
   logic [TEMP_BITS-1:0]           held_reading = '0;
   cfg_type                        csr_shadow = '{RST_TIME_BITS'(DEFAULT_RESET_LOW_US),
                                                  RST_TIME_BITS'(DEFAULT_RESET_REL_US),
                                                  CONV_TIME_BITS'(DEFAULT_CONVERT_US),
                                                  SLOT_TIME_BITS'(DEFAULT_SLOT_US)};

   result_type                     outputs_due [$];
   result_type                     last_tick = '0;

   // run control shared by the sender, the receiver and the tests
   bit                             quiet = 1'b0;
   bit                             hold_request = 1'b0;
   int unsigned                    hold_left = 0;
   int unsigned                    idle_cycles = 0;
   int unsigned                    mismatches = 0;
   int unsigned                    results_checked = 0;
   int unsigned                    ticks_sent = 0;
   int unsigned                    readings_done = 0;
   int unsigned                    negative_readings = 0;
   int unsigned                    timing_settings = 0;

   onewire_temperature_reader #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_request (req_start_request),
      .req_line_level    (req_line_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_low     (rsp_drive_low),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_reading_valid (rsp_reading_valid),
      .rsp_temperature   (rsp_temperature),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // phase timer: counts one tick, true when a phase of this length is over;
   // a zero length still takes one tick and overlong lengths clamp to the counter
   function automatic bit phase_over(input int unsigned duration);
      int unsigned limit;
      limit = (duration > TIMER_MAX) ? TIMER_MAX : duration;
      phase_timer = phase_timer + 1'b1;
      if (phase_timer >= limit) begin
         phase_timer = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic command_bit();
      return COMMAND_SEQ[cmd_slot][bit_pos[2:0]];
   endfunction

   // the line is sampled on the eighth released tick of a read slot
   function automatic bit sample_due();
      return bus_phase == PH_RD_HIGH && COUNT_BITS'(phase_timer + 1'b1) == SAMPLE_AT_US;
   endfunction

   // advance the mirror by one tick and queue the outputs it must show
   function automatic void predict_tick(input logic start, input logic line_bit);
      result_type  due;
      logic [1:0]  finished_slot;
      due = '0;
      case (bus_phase)
         PH_IDLE: begin
            if (start) begin
               bus_phase   = PH_RST_LOW;
               cmd_slot    = '0;
               bit_pos     = '0;
               phase_timer = '0;
            end
         end
         PH_RST_LOW: begin
            if (phase_over(csr_shadow.reset_low_time)) bus_phase = PH_RST_REL;
         end
         PH_RST_REL: begin
            if (phase_over(csr_shadow.reset_release_time)) begin
               bus_phase = PH_WR_LOW;
               bit_pos   = '0;
            end
         end
         PH_WR_LOW: begin
            // a one is a short low pulse, a zero holds the line for the whole slot
            if (phase_over(command_bit() ? SHORT_PHASE_US : csr_shadow.slot_time))
               bus_phase = PH_WR_HIGH;
         end
         PH_WR_HIGH: begin
            if (phase_over(command_bit() ? csr_shadow.slot_time : SHORT_PHASE_US)) begin
               if (bit_pos >= 4'd7) begin
                  finished_slot = cmd_slot;
                  bit_pos       = '0;
                  cmd_slot      = cmd_slot + 1'b1;
                  if (finished_slot == CONVERT_SLOT) begin
                     bus_phase = PH_CONV;
                  end else if (finished_slot == READ_SLOT) begin
                     bus_phase    = PH_RD_LOW;
                     scratch_bits = '0;
                  end else begin
                     bus_phase = PH_WR_LOW;
                  end
               end else begin
                  bit_pos   = bit_pos + 1'b1;
                  bus_phase = PH_WR_LOW;
               end
            end
         end
         PH_CONV: begin
            if (phase_over(csr_shadow.convert_wait_time)) bus_phase = PH_RST_LOW;
         end
         PH_RD_LOW: begin
            if (phase_over(READ_PULSE_US)) bus_phase = PH_RD_HIGH;
         end
         default: begin
            // lsb first: each bit enters at the top and walks down
            if (sample_due()) scratch_bits = {line_bit, scratch_bits[TEMP_BITS-1:1]};
            if (phase_over(SAMPLE_AT_US + csr_shadow.slot_time)) begin
               if (bit_pos >= 4'd15) begin
                  held_reading      = scratch_bits;
                  due.reading_valid = 1'b1;
                  bit_pos           = '0;
                  cmd_slot          = '0;
                  bus_phase         = PH_IDLE;
               end else begin
                  bit_pos   = bit_pos + 1'b1;
                  bus_phase = PH_RD_LOW;
               end
            end
         end
      endcase
      due.drive_low   = bus_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
      due.busy_res    = bus_phase != PH_IDLE;
      due.temperature = held_reading;
      outputs_due.push_back(due);
      last_tick = due;
   endfunction

   task automatic log_failure(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
   endtask

   // one tick beat: random idle gap first, then valid held until accepted
   task automatic send_tick(input logic start, input logic line_bit);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         repeat ($urandom_range(1, 2)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_start_request <= start;
      req_line_level    <= line_bit;
      do @(posedge clock); while (!req_ready);
      predict_tick(start, line_bit);
      ticks_sent++;
   endtask

   // sender stops and waits for every outstanding result beat
   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   // rewrite all four timing registers, with junk above the width of each narrower register
   task automatic load_timing(input int unsigned low_us, input int unsigned rel_us,
                              input int unsigned conv_us, input int unsigned slot_us);
      csr_index_type             regs [4];
      int unsigned               value [4];
      int unsigned               bits [4];
      logic [CSR_DATA_BITS-1:0]  word;
      regs  = '{CSR_RESET_LOW, CSR_RESET_REL, CSR_CONVERT, CSR_SLOT};
      value = '{low_us, rel_us, conv_us, slot_us};
      bits  = '{RST_TIME_BITS, RST_TIME_BITS, CONV_TIME_BITS, SLOT_TIME_BITS};
      wait_results_drained();
      for (int i = 0; i < 4; i++) begin
         word = (CSR_DATA_BITS'($urandom) << bits[i]) | CSR_DATA_BITS'(value[i]);
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= regs[i];
         csr_write_data   <= word;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_shadow.reset_low_time     = RST_TIME_BITS'(low_us);
      csr_shadow.reset_release_time = RST_TIME_BITS'(rel_us);
      csr_shadow.convert_wait_time  = CONV_TIME_BITS'(conv_us);
      csr_shadow.slot_time          = SLOT_TIME_BITS'(slot_us);
      timing_settings++;
   endtask

   // one full reading: idle ticks, start, then ticks until the reading lands;
   // the sensor answers with the target bits on the sample ticks, noise elsewhere
   task automatic run_reading(input logic [TEMP_BITS-1:0] target,
                              input busy_start_mode_type mode, input int unsigned idle_ticks);
      logic start;
      logic line_bit;
      repeat (idle_ticks) send_tick(1'b0, 1'($urandom));
      send_tick(1'b1, 1'($urandom));
      do begin
         case (mode)
            START_NEVER:  start = 1'b0;
            START_ALWAYS: start = 1'b1;
            default:      start = 1'($urandom);
         endcase
         line_bit = sample_due() ? target[bit_pos] : 1'($urandom);
         send_tick(start, line_bit);
      end while (!last_tick.reading_valid);
      readings_done++;
      if (target[TEMP_BITS-1]) negative_readings++;
   endtask

   // a burst of ticks that opens with a start request and does not wait for a reading
   task automatic run_ticks(input busy_start_mode_type mode, input int unsigned count);
      logic start;
      send_tick(1'b1, 1'($urandom));
      repeat (count) begin
         case (mode)
            START_NEVER:  start = 1'b0;
            START_ALWAYS: start = 1'b1;
            default:      start = 1'($urandom);
         endcase
         send_tick(start, 1'($urandom));
      end
   endtask

   // after reset: idle, no reading yet, nothing driven on the line
   task automatic test_reset_state();
      repeat (10) send_tick(1'b0, 1'($urandom));
   endtask

   // zero in every timing register, one full reading of the most negative value,
   // start held high to the completion tick, no idling on either side
   task automatic test_fastest_timing();
      quiet = 1'b1;
      load_timing(0, 0, 0, 0);
      run_reading(16'h8000, START_ALWAYS, 0);
      quiet = 1'b0;
   endtask

   // start toggling at random through the reset pulse and the command slots
   task automatic test_start_while_busy();
      load_timing(2, 3, 5, 12);
      run_ticks(START_RANDOM, 40);
   endtask

   // receiver stops for a long stretch while ticks are offered
   task automatic test_receiver_hold_off();
      load_timing(1, 2, 3, 10);
      hold_request = 1'b1;
      run_ticks(START_RANDOM, 30);
   endtask

   // random timing settings, mostly short, sometimes long, a short burst each
   task automatic test_random_timing();
      int unsigned low_us;
      int unsigned rel_us;
      int unsigned conv_us;
      int unsigned slot_us;
      for (int n = 0; n < 4; n++) begin
         low_us  = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(12);
         rel_us  = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(12);
         conv_us = ($urandom_range(7) == 0) ? $urandom_range(3000) : $urandom_range(40);
         slot_us = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(30);
         load_timing(low_us, rel_us, conv_us, slot_us);
         run_ticks(busy_start_mode_type'($urandom_range(2)), 15);
      end
   endtask

   // every register at its maximum, a burst with no idling at all
   task automatic test_slowest_timing();
      quiet = 1'b1;
      load_timing(4095, 4095, TIMER_MAX, 255);
      run_ticks(START_RANDOM, 30);
      quiet = 1'b0;
   endtask

   // receiver: random ready, a counted hold-off on request, always ready when quiet
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // every result beat against the oldest outstanding prediction
   always @(posedge clock) begin : check_results
      result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (outputs_due.size() == 0) begin
            log_failure($sformatf("result beat %0d arrived with nothing outstanding",
                                  results_checked));
         end else begin
            due = outputs_due.pop_front();
            if (rsp_drive_low !== due.drive_low || rsp_busy_res !== due.busy_res ||
                rsp_reading_valid !== due.reading_valid ||
                rsp_temperature !== due.temperature) begin
               log_failure($sformatf({"result beat %0d: expected drive %b busy %b valid %b ",
                                      "temp %0d, got drive %b busy %b valid %b temp %0d"},
                                     results_checked, due.drive_low, due.busy_res,
                                     due.reading_valid, due.temperature, rsp_drive_low,
                                     rsp_busy_res, rsp_reading_valid, rsp_temperature));
            end
         end
      end
   end

   // watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_fastest_timing();
      test_start_while_busy();
      test_receiver_hold_off();
      test_random_timing();
      test_slowest_timing();
      wait_results_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d ticks, %0d full readings (%0d negative), %0d timing settings",
               ticks_sent, readings_done, negative_readings, timing_settings);
      $display("zero-duration and maximum timing, start requests while busy, receiver hold-off");
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
